// ===== hw/rtl/shape_segment_query_unit_assert.svh =====
// ----------------------------------------------------------------------------
// shape segment query assertion macros
// helpers for concurrent checks on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef SHAPE_SEGMENT_QUERY_UNIT_ASSERT_SVH
`define SHAPE_SEGMENT_QUERY_UNIT_ASSERT_SVH

// same-cycle implication
`define SSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// shared types, defaults and compare helpers of the shape segment query unit
// ----------------------------------------------------------------------------
package ssq_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;

	localparam int KIND_W  = 3;
	localparam int VCNT_W  = 7;
	localparam int VIDX_W  = 6;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int OUT_W   = 8;

	typedef enum logic [2:0] {
		KIND_POINT   = 3'd0,
		KIND_SEGMENT = 3'd1,
		KIND_RAY     = 3'd2,
		KIND_LINE    = 3'd3,
		KIND_POLYGON = 3'd4
	} kind_code_t;

	typedef enum logic [2:0] {
		REG_KIND     = 3'd0,
		REG_FIRST_X  = 3'd1,
		REG_FIRST_Y  = 3'd2,
		REG_SECOND_X = 3'd3,
		REG_SECOND_Y = 3'd4,
		REG_VCOUNT   = 3'd5
	} reg_index_t;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PFIRST,
		ST_PNEXT,
		ST_OPS,
		ST_DRAIN,
		ST_EVAL,
		ST_DONE
	} state_t;

	localparam logic [2:0] LAST_OP_ALL  = 3'd7;
	localparam logic [2:0] LAST_OP_EDGE = 3'd3;

	function automatic logic btw(input logic signed [31:0] p, input logic signed [31:0] a,
		input logic signed [31:0] b);
		return ((a <= p) && (p <= b)) || ((b <= p) && (p <= a));
	endfunction

	function automatic logic ovl(input logic signed [31:0] a, input logic signed [31:0] b,
		input logic signed [31:0] c, input logic signed [31:0] d);
		logic signed [31:0] lo1, hi1, lo2, hi2, lo, hi;
		lo1 = (a < b) ? a : b;
		hi1 = (a < b) ? b : a;
		lo2 = (c < d) ? c : d;
		hi2 = (c < d) ? d : c;
		lo  = (lo1 > lo2) ? lo1 : lo2;
		hi  = (hi1 < hi2) ? hi1 : hi2;
		return lo <= hi;
	endfunction

	// sign product at most zero
	function automatic logic sp_le0(input logic z0, input logic n0, input logic z1,
		input logic n1);
		return z0 || z1 || (n0 != n1);
	endfunction

	// sign product at least zero
	function automatic logic sp_ge0(input logic z0, input logic n0, input logic z1,
		input logic n1);
		return z0 || z1 || (n0 == n1);
	endfunction

endpackage

// ===== hw/rtl/shape_segment_query_unit.sv =====
// ----------------------------------------------------------------------------
// shape_segment_query_unit
// containment and crossing tests of a configured plane shape against point a
// and segment ab, on one shared two-product multiplier under a sequencer
// ----------------------------------------------------------------------------
// usage
// the shape is set over the apb port while the block is idle; polygon
// vertices arrive as load words on the input stream (tuser 0), queries as
// words with tuser 1. a load gives no result, a query gives one output word.
// the input side takes a load word and stays ready; a query word drops
// tready until that query is done. a query on a point, segment, ray or
// line issues eight sign products, one a cycle. a polygon query walks
// the edges in order, stopping at the first edge that meets ab, over the
// vertex count capped at the table size; an unknown shape or an empty
// polygon answers without issuing any products.
// the finished result waits in an output register; a new word is taken
// while it waits, and the next result holds until the receiver takes it.
// reset clears the registers to point shape, vertex count three, and empties
// the output; the vertex memory is not cleared and needs loading first.
// ----------------------------------------------------------------------------
module shape_segment_query_unit
	import ssq_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// vertex_index, x_a, y_a, x_b, y_b
	input  logic [((VIDX_W + 4*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// action
	input  logic [0:0]            s_axis_tuser,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// contains_a, contains_known, crosses_ab
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 1;
	localparam int PW   = 2 * DW;
	localparam int SW   = PW + 1;
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CW0  = $clog2(MAX_VERTICES + 1);
	localparam int CNTW = (CW0 > VCNT_W) ? CW0 : VCNT_W;

	// configuration
	logic [KIND_W-1:0]    kind_q;
	logic signed [CB-1:0] fx_q, fy_q, sx_q, sy_q;
	logic [VCNT_W-1:0]    vcnt_q;
	logic                 cfg_wr;
	reg_index_t           cfg_idx;

	// working registers
	state_t               state_q, state_d;
	logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [CB-1:0] px_q, py_q, qx_q, qy_q;
	logic [2:0]           op_q;
	logic [CNTW-1:0]      edge_q, cnt_q, cnt_in;
	logic signed [PW-1:0] prod1_s1, prod2_s1;
	logic                 add_s1, vld_s1;
	logic [2:0]           tag_s1;
	logic [7:0]           zero_q, neg_q;
	logic [2:0]           res_q, res_d;
	logic                 res_ld, edge_inc, issue;
	logic                 out_valid_q, out_ld;
	logic [2:0]           out_data_q;

	// vertex memory
	logic [2*CB-1:0]      mem [MAX_VERTICES];
	logic [2*CB-1:0]      rd_data_q;
	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr;

	// input fields
	logic                 in_acc, in_action;
	logic [VIDX_W-1:0]    in_vidx;
	logic signed [CB-1:0] in_xa, in_ya, in_xb, in_yb;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_action = s_axis_tuser[0];
	assign in_vidx   = s_axis_tdata[VIDX_W-1:0];
	assign in_xa     = s_axis_tdata[VIDX_W +: CB];
	assign in_ya     = s_axis_tdata[VIDX_W + CB +: CB];
	assign in_xb     = s_axis_tdata[VIDX_W + 2*CB +: CB];
	assign in_yb     = s_axis_tdata[VIDX_W + 3*CB +: CB];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

	// apb register file
	assign pready  = 1'b1;
	assign cfg_idx = reg_index_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && (paddr[ADDR_W-1:2] <= 3'(REG_VCOUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_W'(KIND_POINT);
			fx_q   <= '0;
			fy_q   <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			vcnt_q <= VCNT_W'(3);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_KIND:     kind_q <= pwdata[KIND_W-1:0];
				REG_FIRST_X:  fx_q   <= pwdata[CB-1:0];
				REG_FIRST_Y:  fy_q   <= pwdata[CB-1:0];
				REG_SECOND_X: sx_q   <= pwdata[CB-1:0];
				REG_SECOND_Y: sy_q   <= pwdata[CB-1:0];
				REG_VCOUNT:   vcnt_q <= pwdata[VCNT_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] <= 3'(REG_VCOUNT)) begin
			unique case (cfg_idx)
				REG_KIND:     prdata = DATA_W'(kind_q);
				REG_FIRST_X:  prdata = DATA_W'(unsigned'(fx_q));
				REG_FIRST_Y:  prdata = DATA_W'(unsigned'(fy_q));
				REG_SECOND_X: prdata = DATA_W'(unsigned'(sx_q));
				REG_SECOND_Y: prdata = DATA_W'(unsigned'(sy_q));
				REG_VCOUNT:   prdata = DATA_W'(vcnt_q);
				default:      prdata = '0;
			endcase
		end
	end

	// edge count, saturated
	assign cnt_in = (CNTW'(vcnt_q) > CNTW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : CNTW'(vcnt_q);

	// vertex memory
	assign wr_en = in_acc && (in_action == ACT_LOAD) && (32'(in_vidx) < MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[AW'(in_vidx)] <= {in_ya, in_xa};
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// operand differences
	logic signed [DW-1:0] qp_x, qp_y, ap_x, ap_y, bp_x, bp_y;
	logic signed [DW-1:0] ba_x, ba_y, pa_x, pa_y, qa_x, qa_y;
	logic signed [DW-1:0] m1a, m1b, m2a, m2b;
	logic                 op_add;
	logic signed [SW-1:0] sum;

	assign qp_x = DW'(qx_q) - DW'(px_q);
	assign qp_y = DW'(qy_q) - DW'(py_q);
	assign ap_x = DW'(ax_q) - DW'(px_q);
	assign ap_y = DW'(ay_q) - DW'(py_q);
	assign bp_x = DW'(bx_q) - DW'(px_q);
	assign bp_y = DW'(by_q) - DW'(py_q);
	assign ba_x = DW'(bx_q) - DW'(ax_q);
	assign ba_y = DW'(by_q) - DW'(ay_q);
	assign pa_x = DW'(px_q) - DW'(ax_q);
	assign pa_y = DW'(py_q) - DW'(ay_q);
	assign qa_x = DW'(qx_q) - DW'(ax_q);
	assign qa_y = DW'(qy_q) - DW'(ay_q);

	// det(u, v) = ux*vy - uy*vx, dot(u, v) = ux*vx + uy*vy
	always_comb begin
		op_add = 1'b0;
		m1a = qp_x; m1b = ap_y; m2a = qp_y; m2b = ap_x;
		unique case (op_q)
			3'd0: begin m1a = qp_x; m1b = ap_y; m2a = qp_y; m2b = ap_x; end
			3'd1: begin m1a = qp_x; m1b = bp_y; m2a = qp_y; m2b = bp_x; end
			3'd2: begin m1a = ba_x; m1b = pa_y; m2a = ba_y; m2b = pa_x; end
			3'd3: begin m1a = ba_x; m1b = qa_y; m2a = ba_y; m2b = qa_x; end
			3'd4: begin m1a = ap_x; m1b = qp_x; m2a = ap_y; m2b = qp_y; op_add = 1'b1; end
			3'd5: begin m1a = bp_x; m1b = qp_x; m2a = bp_y; m2b = qp_y; op_add = 1'b1; end
			3'd6: begin m1a = ap_x; m1b = ba_y; m2a = ap_y; m2b = ba_x; end
			3'd7: begin m1a = qp_x; m1b = ba_y; m2a = qp_y; m2b = ba_x; end
			default: ;
		endcase
	end

	assign sum = add_s1 ? (SW'(prod1_s1) + SW'(prod2_s1)) : (SW'(prod1_s1) - SW'(prod2_s1));

	// result logic
	logic signed [31:0] ex_ax, ex_ay, ex_bx, ex_by, ex_px, ex_py, ex_qx, ex_qy;
	logic eq_ap, eq_bp, eq_aq, eq_bq, eq_pq;
	logic onseg_p_ab, onseg_a_pq, seg_hit, rha, rhb, ray_hit;
	logic [2:0] shape_res;

	assign ex_ax = 32'(ax_q);
	assign ex_ay = 32'(ay_q);
	assign ex_bx = 32'(bx_q);
	assign ex_by = 32'(by_q);
	assign ex_px = 32'(px_q);
	assign ex_py = 32'(py_q);
	assign ex_qx = 32'(qx_q);
	assign ex_qy = 32'(qy_q);

	assign eq_ap = (ax_q == px_q) && (ay_q == py_q);
	assign eq_bp = (bx_q == px_q) && (by_q == py_q);
	assign eq_aq = (ax_q == qx_q) && (ay_q == qy_q);
	assign eq_bq = (bx_q == qx_q) && (by_q == qy_q);
	assign eq_pq = (px_q == qx_q) && (py_q == qy_q);

	assign onseg_p_ab = zero_q[2] && btw(ex_px, ex_ax, ex_bx) && btw(ex_py, ex_ay, ex_by);
	assign onseg_a_pq = zero_q[0] && btw(ex_ax, ex_px, ex_qx) && btw(ex_ay, ex_py, ex_qy);
	assign seg_hit = eq_ap || eq_bp || eq_aq || eq_bq ||
		(sp_le0(zero_q[0], neg_q[0], zero_q[1], neg_q[1]) &&
		 sp_le0(zero_q[2], neg_q[2], zero_q[3], neg_q[3]) &&
		 ovl(ex_px, ex_qx, ex_ax, ex_bx) && ovl(ex_py, ex_qy, ex_ay, ex_by));
	assign rha = zero_q[0] && !neg_q[4];
	assign rhb = zero_q[1] && !neg_q[5];
	assign ray_hit = (rha || rhb) ? 1'b1 :
		sp_ge0(zero_q[0], neg_q[0], zero_q[1], neg_q[1]) ? 1'b0 :
		sp_ge0(zero_q[6], neg_q[6], zero_q[7], neg_q[7]);

	// bit 0 contains, bit 1 known, bit 2 crosses
	always_comb begin
		shape_res = 3'b000;
		unique case (kind_q)
			KIND_POINT:   shape_res = {onseg_p_ab, 1'b1, eq_ap};
			KIND_SEGMENT: shape_res = {seg_hit, 1'b1, onseg_a_pq};
			KIND_RAY:     shape_res = eq_pq ? {onseg_p_ab, 1'b1, eq_ap} : {ray_hit, 1'b1, rha};
			KIND_LINE:    shape_res = eq_pq ? {onseg_p_ab, 1'b1, eq_ap} :
				{sp_le0(zero_q[0], neg_q[0], zero_q[1], neg_q[1]), 1'b1, zero_q[0]};
			default:      shape_res = 3'b000;
		endcase
	end

	// sequencer
	logic [CNTW:0] edge_p1, edge_p2;

	assign edge_p1 = (CNTW+1)'(edge_q) + (CNTW+1)'(1);
	assign edge_p2 = (CNTW+1)'(edge_q) + (CNTW+1)'(2);
	assign out_ld  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		issue    = 1'b0;
		res_ld   = 1'b0;
		res_d    = 3'b000;
		edge_inc = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_action == ACT_QUERY)) begin
					priority if (kind_q <= KIND_W'(KIND_LINE)) begin
						state_d = ST_OPS;
					end else if (kind_q == KIND_W'(KIND_POLYGON) && cnt_in != '0) begin
						rd_en   = 1'b1;
						state_d = ST_PFIRST;
					end else begin
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_PFIRST: begin
				rd_en   = 1'b1;
				rd_addr = (cnt_q == CNTW'(1)) ? '0 : AW'(1);
				state_d = ST_PNEXT;
			end
			ST_PNEXT: begin
				state_d = ST_OPS;
			end
			ST_OPS: begin
				issue = 1'b1;
				if (op_q == ((kind_q == KIND_W'(KIND_POLYGON)) ? LAST_OP_EDGE : LAST_OP_ALL))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (kind_q == KIND_W'(KIND_POLYGON)) begin
					priority if (seg_hit) begin
						res_ld  = 1'b1;
						res_d   = 3'b100;
						state_d = ST_DONE;
					end else if (edge_p1 == (CNTW+1)'(cnt_q)) begin
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end else begin
						rd_en    = 1'b1;
						rd_addr  = (edge_p2 == (CNTW+1)'(cnt_q)) ? '0 : AW'(edge_p2);
						edge_inc = 1'b1;
						state_d  = ST_PNEXT;
					end
				end else begin
					res_ld  = 1'b1;
					res_d   = shape_res;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_ld)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q   <= in_xa;
			ay_q   <= in_ya;
			bx_q   <= in_xb;
			by_q   <= in_yb;
			px_q   <= fx_q;
			py_q   <= fy_q;
			qx_q   <= sx_q;
			qy_q   <= sy_q;
			cnt_q  <= cnt_in;
			edge_q <= '0;
			op_q   <= '0;
		end
		if (state_q == ST_PFIRST) begin
			qx_q <= rd_data_q[CB-1:0];
			qy_q <= rd_data_q[2*CB-1:CB];
		end
		if (state_q == ST_PNEXT) begin
			px_q <= qx_q;
			py_q <= qy_q;
			qx_q <= rd_data_q[CB-1:0];
			qy_q <= rd_data_q[2*CB-1:CB];
			op_q <= '0;
		end
		if (issue)
			op_q <= op_q + 3'd1;
		if (edge_inc)
			edge_q <= edge_p1[CNTW-1:0];
		prod1_s1 <= m1a * m1b;
		prod2_s1 <= m2a * m2b;
		add_s1   <= op_add;
		tag_s1   <= op_q;
		if (vld_s1) begin
			zero_q[tag_s1] <= (sum == '0);
			neg_q[tag_s1]  <= sum[SW-1];
		end
		if (res_ld)
			res_q <= res_d;
		if (out_ld)
			out_data_q <= res_q;
	end

endmodule

// ===== hw/rtl/ssq_checker.sv =====
// ----------------------------------------------------------------------------
// ssq_checker
// port-level checks of the shape segment query unit, bound to the top level
// ----------------------------------------------------------------------------
`include "shape_segment_query_unit_assert.svh"

module ssq_checker
	import ssq_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic [0:0]        s_axis_tuser,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready
);

	logic in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	`SSQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
	`SSQ_ASSERT_NEXT(a_load_silent, in_acc && s_axis_tuser[0] == ACT_LOAD && !m_axis_tvalid, !m_axis_tvalid, "vertex load produced a word")
	`SSQ_ASSERT_NEXT(a_query_busy, in_acc && s_axis_tuser[0] == ACT_QUERY, !s_axis_tready, "ready while a query is in work")
	`SSQ_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_W-1:3] == '0, "output padding not zero")
	`SSQ_ASSERT_NOW(a_contains_known, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "containment flagged without known")

endmodule

bind shape_segment_query_unit ssq_checker u_ssq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
